/* hdl/plfs_pkg.sv */
// Shared types, constants and register codes for the line-follow steering core.
// Used by every module under hdl/; depends on nothing else.
`timescale 1ns / 1ps

package plfs_pkg;

    // Channel widths
    localparam int IN_TDATA_W  = 24;   // 19 payload bits padded to 3 bytes
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Field widths
    localparam int LIGHT_W = 10;
    localparam int SPEED_W = 8;
    localparam int GAIN_W  = 24;
    localparam int ERR_W   = 11;
    localparam int DIFF_W  = 12;
    localparam int SUM_W   = 24;
    localparam int TICK_W  = 8;
    localparam int STEP_W  = 4;

    // Product and accumulator widths (gain is zero-extended by one bit)
    localparam int PE_W  = GAIN_W + 1 + ERR_W;    // 36
    localparam int IE_W  = GAIN_W + 1 + SUM_W;    // 49
    localparam int DE_W  = GAIN_W + 1 + DIFF_W;   // 37
    localparam int ACC_W = IE_W + 1;              // 50
    localparam int FRAC_W = 16;                   // Q8.16 gains
    localparam int Q_W   = ACC_W - FRAC_W;

    // Limits
    localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 8'sd100;
    localparam logic signed [SPEED_W-1:0] TURN_LIMIT  = 8'sd100;
    localparam logic signed [SUM_W:0]     SUM_MAX     = 25'sd8388607;
    localparam logic signed [SUM_W:0]     SUM_MIN     = -25'sd8388608;

    // Reset values of the configuration registers
    localparam logic [LIGHT_W-1:0] GRAY_RST   = 10'd512;
    localparam logic [GAIN_W-1:0]  P_GAIN_RST = 24'd121242;
    localparam logic [GAIN_W-1:0]  I_GAIN_RST = 24'd85;
    localparam logic [GAIN_W-1:0]  D_GAIN_RST = 24'd393216;
    localparam logic [TICK_W-1:0]  PERIOD_RST = 8'd50;
    localparam logic [STEP_W-1:0]  STEP_RST   = 4'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAY_LEVEL  = 3'd0,
        REG_P_GAIN      = 3'd1,
        REG_I_GAIN      = 3'd2,
        REG_D_GAIN      = 3'd3,
        REG_RAMP_PERIOD = 3'd4,
        REG_RAMP_STEP   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [LIGHT_W-1:0] gray_level;
        logic [GAIN_W-1:0]  p_gain;
        logic [GAIN_W-1:0]  i_gain;
        logic [GAIN_W-1:0]  d_gain;
        logic [TICK_W-1:0]  ramp_period;
        logic [STEP_W-1:0]  ramp_step;
    } t_cfg;

    // Input word, first member in the highest bits
    typedef struct packed {
        logic                      clear_history;
        logic signed [SPEED_W-1:0] target_speed;
        logic [LIGHT_W-1:0]        light_sample;
    } t_in_word;

    localparam int IN_WORD_W = $bits(t_in_word);

    // Product stage word
    typedef struct packed {
        logic signed [SPEED_W-1:0] forward_cmd;
        logic signed [PE_W-1:0]    p_term;
        logic signed [IE_W-1:0]    i_term;
        logic signed [DE_W-1:0]    d_term;
    } t_prod;

endpackage

/* hdl/plfs_cfg_regs.sv */
// Configuration register file of the line-follow steering core.
// Depends on plfs_pkg for the register codes and the t_cfg struct.
`timescale 1ns / 1ps

module plfs_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [plfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [plfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output plfs_pkg::t_cfg                 o_cfg
);
    import plfs_pkg::*;

    t_cfg r_cfg;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Load the addressed register; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gray_level  <= GRAY_RST;
            r_cfg.p_gain      <= P_GAIN_RST;
            r_cfg.i_gain      <= I_GAIN_RST;
            r_cfg.d_gain      <= D_GAIN_RST;
            r_cfg.ramp_period <= PERIOD_RST;
            r_cfg.ramp_step   <= STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRAY_LEVEL:  r_cfg.gray_level  <= i_cfg_data[LIGHT_W-1:0];
                REG_P_GAIN:      r_cfg.p_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_I_GAIN:      r_cfg.i_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_D_GAIN:      r_cfg.d_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_RAMP_PERIOD: r_cfg.ramp_period <= i_cfg_data[TICK_W-1:0];
                REG_RAMP_STEP:   r_cfg.ramp_step   <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* hdl/plfs_err_stage.sv */
// Input register, error/integral/ramp state and the three gain products.
// Depends on plfs_pkg for t_cfg, t_in_word, t_prod and the limits.
`timescale 1ns / 1ps

module plfs_err_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plfs_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  plfs_pkg::t_in_word i_in_word,
    output logic               o_prod_valid,
    input  logic               i_prod_ready,
    output plfs_pkg::t_prod    o_prod
);
    import plfs_pkg::*;

    // Pipeline registers
    logic     r_in_vld;
    t_in_word r_in;
    logic     r_prod_vld;
    t_prod    r_prod;

    // Controller state
    logic signed [SUM_W-1:0]   r_err_sum,  n_err_sum;
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [SPEED_W-1:0] r_fwd,      n_fwd;
    logic [TICK_W-1:0]         r_ticks,    n_ticks;

    logic                      w_take;
    logic signed [SUM_W-1:0]   w_sum_old;
    logic signed [ERR_W-1:0]   w_last_old;
    logic signed [ERR_W-1:0]   w_gray, w_light, w_e;
    logic signed [SUM_W:0]     w_sum_wide;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [SPEED_W-1:0] w_lim;
    logic [TICK_W-1:0]         w_ticks;
    logic signed [SPEED_W:0]   w_step, w_up, w_dn, w_lim9;
    t_prod                     w_prod;

    assign w_take       = !r_prod_vld || i_prod_ready;
    assign o_in_ready   = !r_in_vld || w_take;
    assign o_prod_valid = r_prod_vld;
    assign o_prod       = r_prod;

    // Error, integral, derivative and ramp for the word in the input register
    always_comb begin
        w_sum_old  = r_in.clear_history ? '0 : r_err_sum;
        w_last_old = r_in.clear_history ? '0 : r_last_err;
        w_gray     = $signed({1'b0, i_cfg.gray_level});
        w_light    = $signed({1'b0, r_in.light_sample});
        w_e        = (r_in.target_speed > 8'sd0) ? (w_gray - w_light) : (w_light - w_gray);

        // saturate the running sum
        w_sum_wide = (SUM_W+1)'(w_sum_old) + (SUM_W+1)'(w_e);
        if (w_sum_wide > SUM_MAX) begin
            n_err_sum = SUM_MAX[SUM_W-1:0];
        end else if (w_sum_wide < SUM_MIN) begin
            n_err_sum = SUM_MIN[SUM_W-1:0];
        end else begin
            n_err_sum = w_sum_wide[SUM_W-1:0];
        end
        w_diff = DIFF_W'(w_e) - DIFF_W'(w_last_old);

        // step the forward level toward the clamped target
        if (r_in.target_speed > SPEED_LIMIT) begin
            w_lim = SPEED_LIMIT;
        end else if (r_in.target_speed < -SPEED_LIMIT) begin
            w_lim = -SPEED_LIMIT;
        end else begin
            w_lim = r_in.target_speed;
        end
        w_lim9  = (SPEED_W+1)'(w_lim);
        w_step  = $signed({{(SPEED_W+1-STEP_W){1'b0}}, i_cfg.ramp_step});
        w_up    = (SPEED_W+1)'(r_fwd) + w_step;
        w_dn    = (SPEED_W+1)'(r_fwd) - w_step;
        w_ticks = r_ticks + TICK_W'(1);
        n_ticks = w_ticks;
        n_fwd   = r_fwd;
        if (w_ticks >= i_cfg.ramp_period) begin
            n_ticks = '0;
            if (w_lim >= r_fwd) begin
                n_fwd = (w_up > w_lim9) ? w_lim : w_up[SPEED_W-1:0];
            end else begin
                n_fwd = (w_dn < w_lim9) ? w_lim : w_dn[SPEED_W-1:0];
            end
        end

        // gain products
        w_prod.forward_cmd = n_fwd;
        w_prod.p_term = PE_W'($signed({1'b0, i_cfg.p_gain})) * PE_W'(w_e);
        w_prod.i_term = IE_W'($signed({1'b0, i_cfg.i_gain})) * IE_W'(n_err_sum);
        w_prod.d_term = DE_W'($signed({1'b0, i_cfg.d_gain})) * DE_W'(w_diff);
    end

    // Hold the input word until the product stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (w_take) begin
            r_in_vld <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
    end

    // Advance into the product register and commit the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_err_sum  <= '0;
            r_last_err <= '0;
            r_fwd      <= '0;
            r_ticks    <= '0;
        end else if (w_take) begin
            r_prod_vld <= r_in_vld;
            if (r_in_vld) begin
                r_err_sum  <= n_err_sum;
                r_last_err <= w_e;
                r_fwd      <= n_fwd;
                r_ticks    <= n_ticks;
            end
        end
        if (w_take) begin
            r_prod <= w_prod;
        end
    end

endmodule

/* hdl/plfs_out_stage.sv */
// Sum of the gain products, Q8.16 floor shift, turn clamp and result register.
// Depends on plfs_pkg for t_prod and the widths.
`timescale 1ns / 1ps

module plfs_out_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_prod_valid,
    output logic                                o_prod_ready,
    input  plfs_pkg::t_prod                     i_prod,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [plfs_pkg::SPEED_W-1:0] o_forward_cmd,
    output logic signed [plfs_pkg::SPEED_W-1:0] o_turn_cmd
);
    import plfs_pkg::*;

    logic                      r_out_vld;
    logic signed [SPEED_W-1:0] r_fwd;
    logic signed [SPEED_W-1:0] r_turn, n_turn;

    logic signed [ACC_W-1:0] w_acc;
    logic signed [Q_W-1:0]   w_q;

    assign o_prod_ready  = !r_out_vld || i_ready;
    assign o_valid       = r_out_vld;
    assign o_forward_cmd = r_fwd;
    assign o_turn_cmd    = r_turn;

    // Sum, floor shift and negate with clamp
    always_comb begin
        w_acc = ACC_W'(i_prod.p_term) + ACC_W'(i_prod.i_term) + ACC_W'(i_prod.d_term);
        w_q   = w_acc[ACC_W-1:FRAC_W];
        if (w_q > Q_W'(TURN_LIMIT)) begin
            n_turn = -TURN_LIMIT;
        end else if (w_q < -Q_W'(TURN_LIMIT)) begin
            n_turn = TURN_LIMIT;
        end else begin
            n_turn = -w_q[SPEED_W-1:0];
        end
    end

    // Result register; holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_prod_ready) begin
            r_out_vld <= i_prod_valid;
        end
        if (o_prod_ready) begin
            r_fwd  <= i_prod.forward_cmd;
            r_turn <= n_turn;
        end
    end

endmodule

/* hdl/pid_line_follow_steering_core.sv */
// Line-follow PID steering core, top level.
// Channels: s_axis carries one sample word per transfer (light level, target
//   speed, clear flag); m_axis returns one word per sample (forward and turn
//   commands); the cfg channel writes gray level, gains and ramp settings.
// Throughput: one sample per clock while m_axis_tready is high. Every stage
//   advances in the same cycle; controller state feeds back in the error stage only.
// Path: after the s_axis transfer the word loads the input register, then the
//   product register (three gain multiplies), then the result register, which
//   drives m_axis_tvalid.
// Stall: when m_axis_tready is low the result register holds, and the stages
//   behind it fill; s_axis_tready drops once all three hold a word.
// Reset (synchronous, i_rst_n low): all pipeline stages empty, integral,
//   previous error, forward level and ramp counter at zero, configuration
//   registers at their defaults. No clearing pass; ready the next cycle.
// Configuration writes are taken every cycle and should be made while the
//   pipeline is empty.
// Depends on plfs_pkg, plfs_cfg_regs, plfs_err_stage, plfs_out_stage.
`timescale 1ns / 1ps

module pid_line_follow_steering_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: [9:0] light_sample, [17:10] target_speed, [18] clear_history, [23:19] zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [plfs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tdata: [7:0] forward_cmd, [15:8] turn_cmd
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [plfs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [plfs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [plfs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import plfs_pkg::*;

    t_cfg                      w_cfg;
    t_in_word                  w_in_word;
    t_prod                     w_prod;
    logic                      w_prod_valid;
    logic                      w_prod_ready;
    logic signed [SPEED_W-1:0] w_forward_cmd;
    logic signed [SPEED_W-1:0] w_turn_cmd;

    assign w_in_word    = s_axis_tdata[IN_WORD_W-1:0];
    assign m_axis_tdata = {w_turn_cmd, w_forward_cmd};

    plfs_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    plfs_err_stage u_err_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_word    (w_in_word),
        .o_prod_valid (w_prod_valid),
        .i_prod_ready (w_prod_ready),
        .o_prod       (w_prod)
    );

    plfs_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_prod_valid  (w_prod_valid),
        .o_prod_ready  (w_prod_ready),
        .i_prod        (w_prod),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_forward_cmd (w_forward_cmd),
        .o_turn_cmd    (w_turn_cmd)
    );

endmodule
